// ===== rtl/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and character constants for the source comment stripper.
// ----------------------------------------------------------------------------
package scs_pkg;

  // Characters the scanner reacts to.
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;

  // Most results a single input beat can cause.
  localparam int unsigned MaxResults = 3;

  // Input beat payload.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } scs_in_t;

  // Output beat payload.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       text_end;
  } scs_out_t;

endpackage

// ===== rtl/scs_if.sv =====
// ----------------------------------------------------------------------------
// scs_in_if / scs_out_if
// Valid/ready stream channels for the comment stripper input and output.
// ----------------------------------------------------------------------------
interface scs_in_if;
  logic             valid;
  logic             ready;
  scs_pkg::scs_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface scs_out_if;
  logic              valid;
  logic              ready;
  scs_pkg::scs_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/source_comment_stripper.sv =====
// ----------------------------------------------------------------------------
// source_comment_stripper
// Streaming C-style comment remover with string pass-through.
// ----------------------------------------------------------------------------
// Source text enters one byte per beat on in_i; stripped text leaves one byte
// per beat on out_o. Block and line comments are removed, quoted strings pass
// unchanged (a backslash escapes a following quote), and outside strings a
// newline becomes a space, as does the newline closing a line comment. A
// slash is held one byte until it is known whether it opens a comment. On a
// beat marked final_byte any held slash is emitted, an open string gets a
// closing quote, and the last result carries text_end; if nothing else is
// due a bare end marker (byte_valid low) is sent. The scanner then returns
// to normal text. Rate: one input byte per cycle while each byte causes at
// most one result and out_o is not stalled; a byte causing two or three
// results holds the input until the single output port has drained the
// four-entry result queue to one result. Input is accepted whenever the
// queue holds at most one result, so a stalled output does not block the
// next byte. Results are registered in the queue before leaving on out_o.
// ----------------------------------------------------------------------------
module source_comment_stripper (
  input  logic        clk_i,
  input  logic        rst_ni,
  scs_in_if.sink      in_i,
  scs_out_if.source   out_o
);

  // Scanner modes.
  localparam logic [2:0] ModeNormal    = 3'd0;
  localparam logic [2:0] ModeSlash     = 3'd1;
  localparam logic [2:0] ModeString    = 3'd2;
  localparam logic [2:0] ModeStrEsc    = 3'd3;
  localparam logic [2:0] ModeLine      = 3'd4;
  localparam logic [2:0] ModeBlock     = 3'd5;
  localparam logic [2:0] ModeBlockStar = 3'd6;

  // Result queue depth: one waiting result plus a full burst from one beat.
  localparam int unsigned QDepth = scs_pkg::MaxResults + 1;

  logic [2:0]        mode_q, mode_d;
  logic [2:0]        cnt_q, cnt_d;
  scs_pkg::scs_out_t slot_q [QDepth];
  scs_pkg::scs_out_t slot_d [QDepth];

  logic              acc, pop;
  logic [7:0]        b;
  logic              fin;

  // Per-beat scan results.
  scs_pkg::scs_out_t step_res [scs_pkg::MaxResults];
  logic [1:0]        step_n;
  logic [2:0]        step_mode;

  // Plain-text handling of the current byte, shared by normal mode and the
  // byte after a held slash that did not open a comment.
  logic              plain_emit;
  logic [7:0]        plain_byte;
  logic [2:0]        plain_mode;

  assign b   = in_i.data.in_byte;
  assign fin = in_i.data.final_byte;

  // Accept while at most one result waits; a beat adds at most three.
  assign in_i.ready  = (cnt_q <= 3'd1);
  assign acc         = in_i.valid && in_i.ready;
  assign out_o.valid = (cnt_q != 3'd0);
  assign out_o.data  = slot_q[0];
  assign pop         = out_o.valid && out_o.ready;

  always_comb begin
    plain_emit = 1'b1;
    plain_byte = b;
    plain_mode = ModeNormal;
    if (b == scs_pkg::ChQuote) begin
      plain_mode = ModeString;
    end else if (b == scs_pkg::ChSlash) begin
      plain_emit = 1'b0;
      plain_mode = ModeSlash;
    end else if (b == scs_pkg::ChNl) begin
      plain_byte = scs_pkg::ChSpace;
    end
  end

  // Scan one byte: up to three results and the next mode.
  always_comb begin
    for (int i = 0; i < scs_pkg::MaxResults; i++) begin
      step_res[i] = '0;
    end
    step_n    = 2'd0;
    step_mode = mode_q;

    case (mode_q)
      ModeSlash: begin
        if (b == scs_pkg::ChStar) begin
          step_mode = ModeBlock;
        end else if (b == scs_pkg::ChSlash) begin
          step_mode = ModeLine;
        end else begin
          // Release the held slash, then treat the byte as plain text.
          step_res[0].out_byte   = scs_pkg::ChSlash;
          step_res[0].byte_valid = 1'b1;
          step_n                 = 2'd1;
          if (plain_emit) begin
            step_res[1].out_byte   = plain_byte;
            step_res[1].byte_valid = 1'b1;
            step_n                 = 2'd2;
          end
          step_mode = plain_mode;
        end
      end
      ModeString: begin
        step_res[0].out_byte   = b;
        step_res[0].byte_valid = 1'b1;
        step_n                 = 2'd1;
        if (b == scs_pkg::ChQuote) begin
          step_mode = ModeNormal;
        end else if (b == scs_pkg::ChBslash) begin
          step_mode = ModeStrEsc;
        end
      end
      ModeStrEsc: begin
        step_res[0].out_byte   = b;
        step_res[0].byte_valid = 1'b1;
        step_n                 = 2'd1;
        if (b != scs_pkg::ChBslash) begin
          step_mode = ModeString;
        end
      end
      ModeLine: begin
        if (b == scs_pkg::ChNl) begin
          step_res[0].out_byte   = scs_pkg::ChSpace;
          step_res[0].byte_valid = 1'b1;
          step_n                 = 2'd1;
          step_mode              = ModeNormal;
        end
      end
      ModeBlock: begin
        if (b == scs_pkg::ChStar) begin
          step_mode = ModeBlockStar;
        end
      end
      ModeBlockStar: begin
        if (b == scs_pkg::ChSlash) begin
          step_mode = ModeNormal;
        end else if (b != scs_pkg::ChStar) begin
          step_mode = ModeBlock;
        end
      end
      default: begin
        if (plain_emit) begin
          step_res[0].out_byte   = plain_byte;
          step_res[0].byte_valid = 1'b1;
          step_n                 = 2'd1;
        end
        step_mode = plain_mode;
      end
    endcase

    // End of text: flush a held slash, close an open string, mark the end.
    if (fin) begin
      if (step_mode == ModeSlash) begin
        step_res[step_n].out_byte   = scs_pkg::ChSlash;
        step_res[step_n].byte_valid = 1'b1;
        step_n                      = step_n + 2'd1;
      end else if (step_mode == ModeString || step_mode == ModeStrEsc) begin
        step_res[step_n].out_byte   = scs_pkg::ChQuote;
        step_res[step_n].byte_valid = 1'b1;
        step_n                      = step_n + 2'd1;
      end
      if (step_n == 2'd0) begin
        // Bare end marker: byte_valid stays low.
        step_n = 2'd1;
      end
      step_res[step_n - 2'd1].text_end = 1'b1;
      step_mode = ModeNormal;
    end
  end

  // Result queue: drop the head on pop, append new results behind the rest.
  always_comb begin
    logic [2:0] base;
    logic [2:0] k;
    base = cnt_q - {2'b00, pop};
    for (int i = 0; i < QDepth; i++) begin
      if (pop && (i < QDepth - 1)) begin
        slot_d[i] = slot_q[i + 1];
      end else begin
        slot_d[i] = slot_q[i];
      end
      k = 3'(i) - base;
      if (acc && (k < {1'b0, step_n})) begin
        slot_d[i] = step_res[k[1:0]];
      end
    end
    cnt_d = base + (acc ? {1'b0, step_n} : 3'd0);
  end

  assign mode_d = acc ? step_mode : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
      cnt_q  <= 3'd0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  // Payload holds no reset.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  // Queue never overflows its four entries.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(QDepth))
    else $error("result queue count out of range");

  // A final beat always returns the scanner to normal text.
  a_final_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && fin) |=> (mode_q == ModeNormal))
    else $error("scanner not reset after final byte");

  // A final beat always leaves at least one result waiting.
  a_final_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && fin) |=> (cnt_q != 3'd0))
    else $error("final byte produced no result");

  // A result without a byte is only ever the end marker.
  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.data.byte_valid) |->
      (out_o.data.text_end && out_o.data.out_byte == 8'h00))
    else $error("bare result is not an end marker");

endmodule
